@@ sv/antialiased_window_mask_pixel_unit_defines.svh @@
// Assertion macros for the window mask unit. They expect clk and rst in scope.
`ifndef ANTIALIASED_WINDOW_MASK_PIXEL_UNIT_DEFINES_SVH
`define ANTIALIASED_WINDOW_MASK_PIXEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AWM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AWM_ASSERT(label, prop, msg)
`define AWM_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ sv/awm_pkg.sv @@
package awm_pkg;

  localparam int QF = 28;
  localparam logic [28:0] QONE = 29'h1000_0000;

  localparam logic [1:0] ORD_SMOOTH = 2'd0;
  localparam logic [1:0] ORD_FILLET = 2'd1;
  localparam logic [1:0] ORD_HANN   = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ORDER  = 2'd2;
  localparam logic [1:0] REG_ROUND  = 2'd3;

  typedef struct packed {
    logic       zero;
    logic       rnd;
    logic [1:0] ord;
    logic [3:0] sat;
  } awm_ctl_t;

endpackage

@@ sv/awm_div.sv @@
module awm_div #(
  parameter int QW = 32,
  parameter int RW = 28,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [RW-1:0] rem0,
  input  logic [QW-1:0] nlo,
  input  logic [RW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          v    [0:QW];
  logic [RW-1:0] rem  [0:QW];
  logic [QW-1:0] lo   [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [RW-1:0] d    [0:QW];
  logic [SW-1:0] sd   [0:QW];

  assign v[0]   = vin;
  assign rem[0] = rem0;
  assign lo[0]  = nlo;
  assign q[0]   = '0;
  assign d[0]   = den;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW+1:0] diff;
    logic          ge;
    assign diff = {1'b0, rem[k], lo[k][QW-1]} - {2'b00, d[k]};
    assign ge   = ~diff[RW+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[RW-1:0] : {rem[k][RW-2:0], lo[k][QW-1]};
        lo[k+1]  <= {lo[k][QW-2:0], 1'b0};
        q[k+1]   <= {q[k][QW-2:0], ge};
        d[k+1]   <= d[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign vout     = v[QW];
  assign quo      = q[QW];
  assign side_out = sd[QW];

endmodule

@@ sv/awm_prof.sv @@
module awm_prof (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  logic [32:0]      iu,
  input  logic [32:0]      ou,
  input  awm_pkg::awm_ctl_t tag_in,
  output logic             vout,
  output logic [28:0]      val,
  output awm_pkg::awm_ctl_t tag_out
);

  typedef struct packed {
    logic              zero;
    logic              inner;
    logic [1:0]        ord;
    logic [28:0]       half;
    logic [28:0]       hann;
    awm_pkg::awm_ctl_t tag;
  } pside_t;

  // P1: margins and branch flags
  logic              p1_v;
  logic [28:0]       p1_a;
  logic [32:0]       p1_d;
  logic              p1_zero;
  logic              p1_inner;
  logic [28:0]       p1_half;
  logic [1:0]        p1_ord;
  awm_pkg::awm_ctl_t p1_tag;
  logic [33:0]       sum;
  logic [32:0]       hs;

  assign sum = {1'b0, iu} + {1'b0, ou};
  assign hs  = sum[33:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (en) begin
      p1_v <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a     <= awm_pkg::QONE - ou[28:0];
      p1_d     <= iu - ou;
      p1_zero  <= ou >= 33'(awm_pkg::QONE);
      p1_inner <= iu <= 33'(awm_pkg::QONE);
      p1_half  <= awm_pkg::QONE - hs[28:0];
      p1_ord   <= tag_in.ord;
      p1_tag   <= tag_in;
    end
  end

  // P2: square of margin, divisor
  logic              p2_v;
  logic [57:0]       p2_sq;
  logic [28:0]       p2_a;
  logic [33:0]       p2_den;
  pside_t            p2_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sq        <= p1_a * p1_a;
      p2_a         <= p1_a;
      p2_den       <= (p1_ord == awm_pkg::ORD_SMOOTH) ? {1'b0, p1_d} : {p1_d, 1'b0};
      p2_sd.zero   <= p1_zero;
      p2_sd.inner  <= p1_inner;
      p2_sd.ord    <= p1_ord;
      p2_sd.half   <= p1_half;
      p2_sd.hann   <= '0;
      p2_sd.tag    <= p1_tag;
    end
  end

  logic        is_smooth;
  logic [33:0] drem0;
  logic [27:0] dlo;
  pside_t      dside;
  logic        dv;
  logic [27:0] dq;
  pside_t      dso;

  assign is_smooth = p2_sd.ord == awm_pkg::ORD_SMOOTH;
  assign drem0 = is_smooth ? {5'b0, p2_a} : {5'b0, p2_sq[56:28]};
  assign dlo   = is_smooth ? 28'b0 : p2_sq[27:0];

  always_comb begin
    dside      = p2_sd;
    dside.hann = p2_sq[56:28];
  end

  awm_div #(
    .QW(28),
    .RW(34),
    .SW($bits(pside_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (p2_v),
    .rem0     (drem0),
    .nlo      (dlo),
    .den      (p2_den),
    .side_in  (dside),
    .vout     (dv),
    .quo      (dq),
    .side_out (dso)
  );

  // P4: s squared
  logic        p4_v;
  logic [55:0] s_sq;
  logic [27:0] p4_s2;
  logic [27:0] p4_s;
  pside_t      p4_sd;

  assign s_sq = dq * dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else if (en) begin
      p4_v <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_s2 <= s_sq[55:28];
      p4_s  <= dq;
      p4_sd <= dso;
    end
  end

  // P5: smoothstep tail and profile select
  logic [29:0] lin;
  logic [57:0] t_full;
  logic [28:0] val_next;

  assign lin    = 30'h3000_0000 - {1'b0, p4_s, 1'b0};
  assign t_full = p4_s2 * lin;

  always_comb begin
    if (p4_sd.zero) begin
      val_next = '0;
    end else begin
      case (p4_sd.ord)
        awm_pkg::ORD_SMOOTH: val_next = p4_sd.inner ? awm_pkg::QONE : t_full[56:28];
        awm_pkg::ORD_FILLET: val_next = p4_sd.inner ? p4_sd.half : {1'b0, p4_s};
        default:             val_next = p4_sd.hann;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= p4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val     <= val_next;
      tag_out <= p4_sd.tag;
    end
  end

endmodule

@@ sv/antialiased_window_mask_pixel_unit.sv @@
// Throughput: one pixel per cycle while the skid register is empty (s_tready
// low otherwise); restoring dividers of 32 and 28 stages in series set the depth,
// each retiring one quotient bit per stage.
// Reset (synchronous, rst high): pipeline and output emptied, registers
// return to width 256, height 256, smoothstep order, round mode.
`include "antialiased_window_mask_pixel_unit_defines.svh"

module antialiased_window_mask_pixel_unit #(
  parameter int MAX_DIM       = 4096,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] pixel_col, [23:12] pixel_row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [((OUT_FRAC_BITS+8)/8)*8-1:0] m_tdata  // [OUT_FRAC_BITS:0] mask_value
);

  localparam int OW = OUT_FRAC_BITS + 1;
  localparam int TDW = ((OUT_FRAC_BITS + 8) / 8) * 8;
  localparam int SH = awm_pkg::QF - OUT_FRAC_BITS;
  localparam logic [16:0] MAXD = 17'(MAX_DIM);
  localparam logic [28:0] FULL = 29'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic [13:0] a4;
    logic [13:0] ir4;
    logic [13:0] or4;
  } axis_t;

  logic [12:0] cfg_w;
  logic [12:0] cfg_h;
  logic [1:0]  cfg_ord;
  logic        cfg_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w   <= 13'd256;
      cfg_h   <= 13'd256;
      cfg_ord <= awm_pkg::ORD_SMOOTH;
      cfg_rnd <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        awm_pkg::REG_WIDTH:  cfg_w   <= cfg_data;
        awm_pkg::REG_HEIGHT: cfg_h   <= cfg_data;
        awm_pkg::REG_ORDER:  cfg_ord <= cfg_data[1:0];
        awm_pkg::REG_ROUND:  cfg_rnd <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic axis_t axis_calc(input logic [11:0] idx, input logic [12:0] n_raw,
                                      input logic [1:0] ord);
    logic [12:0] n;
    logic [12:0] twice;
    logic [12:0] a;
    logic [13:0] m4;
    axis_t       r;
    n = ({4'b0, n_raw} > MAXD) ? MAXD[12:0] : n_raw;
    twice = {idx, 1'b1};
    a = (twice >= n) ? twice - n : n - twice;
    case (ord)
      awm_pkg::ORD_SMOOTH: m4 = 14'd8;
      awm_pkg::ORD_FILLET: m4 = 14'd4;
      default:             m4 = 14'd0;
    endcase
    r.a4  = {a, 1'b0};
    r.or4 = {n, 1'b0};
    r.ir4 = ({1'b0, n} > m4) ? ({n, 1'b0} - m4) : {1'b0, n};
    return r;
  endfunction

  logic ce;
  logic sk_v;
  assign ce = ~sk_v;
  assign s_tready = ce;

  // S1: offsets and semidiameters
  logic              s1_v;
  axis_t             s1_x;
  axis_t             s1_y;
  awm_pkg::awm_ctl_t s1_ctl;
  logic [1:0]        ordc;

  assign ordc = (cfg_ord > awm_pkg::ORD_HANN) ? awm_pkg::ORD_HANN : cfg_ord;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (ce) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_x        <= axis_calc(s_tdata[11:0], cfg_w, ordc);
      s1_y        <= axis_calc(s_tdata[23:12], cfg_h, ordc);
      s1_ctl.zero <= (cfg_w == 13'd0) || (cfg_h == 13'd0);
      s1_ctl.rnd  <= cfg_rnd;
      s1_ctl.ord  <= ordc;
      s1_ctl.sat  <= '0;
    end
  end

  // S2: squares
  logic              s2_v;
  logic [27:0]       ax, rix, rox, ay, riy, roy;
  awm_pkg::awm_ctl_t s2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (ce) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ax     <= s1_x.a4 * s1_x.a4;
      rix    <= s1_x.ir4 * s1_x.ir4;
      rox    <= s1_x.or4 * s1_x.or4;
      ay     <= s1_y.a4 * s1_y.a4;
      riy    <= s1_y.ir4 * s1_y.ir4;
      roy    <= s1_y.or4 * s1_y.or4;
      s2_ctl <= s1_ctl;
    end
  end

  // squared ratio dividers; saturation when a^2 >= 16 r^2
  awm_pkg::awm_ctl_t dctl;
  awm_pkg::awm_ctl_t rctl;
  logic              rv;
  logic [31:0]       qxi, qxo, qyi, qyo;

  always_comb begin
    dctl     = s2_ctl;
    dctl.sat = {{4'b0, ay[27:4]} >= roy, {4'b0, ay[27:4]} >= riy,
                {4'b0, ax[27:4]} >= rox, {4'b0, ax[27:4]} >= rix};
  end

  awm_div #(.QW(32), .RW(28), .SW($bits(awm_pkg::awm_ctl_t))) u_div_xi (
    .clk(clk), .rst(rst), .en(ce), .vin(s2_v),
    .rem0({4'b0, ax[27:4]}), .nlo({ax[3:0], 28'b0}), .den(rix), .side_in(dctl),
    .vout(rv), .quo(qxi), .side_out(rctl)
  );

  awm_div #(.QW(32), .RW(28), .SW(1)) u_div_xo (
    .clk(clk), .rst(rst), .en(ce), .vin(s2_v),
    .rem0({4'b0, ax[27:4]}), .nlo({ax[3:0], 28'b0}), .den(rox), .side_in(1'b0),
    .vout(), .quo(qxo), .side_out()
  );

  awm_div #(.QW(32), .RW(28), .SW(1)) u_div_yi (
    .clk(clk), .rst(rst), .en(ce), .vin(s2_v),
    .rem0({4'b0, ay[27:4]}), .nlo({ay[3:0], 28'b0}), .den(riy), .side_in(1'b0),
    .vout(), .quo(qyi), .side_out()
  );

  awm_div #(.QW(32), .RW(28), .SW(1)) u_div_yo (
    .clk(clk), .rst(rst), .en(ce), .vin(s2_v),
    .rem0({4'b0, ay[27:4]}), .nlo({ay[3:0], 28'b0}), .den(roy), .side_in(1'b0),
    .vout(), .quo(qyo), .side_out()
  );

  // S3: saturate, combine for round mode
  logic [31:0]       iux, oux, iuy, ouy;
  logic              s3_v;
  logic [32:0]       p0_iu, p0_ou, p1_iu, p1_ou;
  awm_pkg::awm_ctl_t s3_ctl;

  assign iux = rctl.sat[0] ? 32'hFFFF_FFFF : qxi;
  assign oux = rctl.sat[1] ? 32'hFFFF_FFFF : qxo;
  assign iuy = rctl.sat[2] ? 32'hFFFF_FFFF : qyi;
  assign ouy = rctl.sat[3] ? 32'hFFFF_FFFF : qyo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (ce) begin
      s3_v <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p0_iu  <= rctl.rnd ? {1'b0, iux} + {1'b0, iuy} : {1'b0, iux};
      p0_ou  <= rctl.rnd ? {1'b0, oux} + {1'b0, ouy} : {1'b0, oux};
      p1_iu  <= {1'b0, iuy};
      p1_ou  <= {1'b0, ouy};
      s3_ctl <= rctl;
    end
  end

  logic              pv0;
  logic [28:0]       v0, v1;
  awm_pkg::awm_ctl_t pctl;

  awm_prof u_prof0 (
    .clk(clk), .rst(rst), .en(ce), .vin(s3_v),
    .iu(p0_iu), .ou(p0_ou), .tag_in(s3_ctl),
    .vout(pv0), .val(v0), .tag_out(pctl)
  );

  awm_prof u_prof1 (
    .clk(clk), .rst(rst), .en(ce), .vin(s3_v),
    .iu(p1_iu), .ou(p1_ou), .tag_in(s3_ctl),
    .vout(), .val(v1), .tag_out()
  );

  // F1: separable product (profile 0 alone in round mode)
  logic        f_v;
  logic [28:0] f_val;
  logic [57:0] prod;

  assign prod = v0 * v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (ce) begin
      f_v <= pv0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_val <= pctl.zero ? 29'd0 : (pctl.rnd ? v0 : prod[56:28]);
    end
  end

  logic [28:0]   shifted;
  logic [OW-1:0] pd;

  assign shifted = f_val >> SH;
  assign pd = (shifted > FULL) ? FULL[OW-1:0] : shifted[OW-1:0];

  // output register plus skid
  logic [OW-1:0] out_d;
  logic [OW-1:0] sk_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_v     <= 1'b0;
    end else if (sk_v) begin
      if (m_tready) begin
        out_d <= sk_d;
        sk_v  <= 1'b0;
      end
    end else if (f_v) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
        out_d    <= pd;
      end else begin
        sk_v <= 1'b1;
        sk_d <= pd;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = TDW'(out_d);

  `AWM_ASSERT(a_skid_needs_out, sk_v |-> m_tvalid, "skid holds a beat while output is empty")
  `AWM_ASSERT(a_mask_range, m_tvalid |-> ({{(29-OW){1'b0}}, out_d} <= FULL), "mask above 1.0")
  `AWM_ASSERT_RST(a_reset_empty, rst |=> (!m_tvalid && s_tready), "pipeline not empty after reset")

endmodule

@@ bench/antialiased_window_mask_pixel_unit_checker.sv @@
`timescale 1ns / 1ps

module antialiased_window_mask_pixel_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  localparam logic [63:0] ONE_Q = 64'd1 << awm_pkg::QF;
  localparam logic [63:0] SAT_Q = 64'hFFFF_FFFF;
  localparam int MAX_DIM = 4096;

  logic [12:0] width_r, height_r;
  logic [1:0]  order_r;
  logic        round_r;
  logic [16:0] mask_q[$];

  function automatic logic [63:0] sq_ratio(input logic [63:0] a4, input logic [63:0] r4);
    logic [63:0] q;
    q = ((a4 * a4) << awm_pkg::QF) / (r4 * r4);
    return (q > SAT_Q) ? SAT_Q : q;
  endfunction

  function automatic void axis_ratios(input logic [63:0] idx, input logic [63:0] n,
                                      input logic [63:0] ord, output logic [63:0] iu2,
                                      output logic [63:0] ou2);
    logic [63:0] twice, a, m4, ir4;
    twice = 2 * idx + 1;
    a = (twice >= n) ? twice - n : n - twice;
    m4 = 4 * (2 - ord);
    ir4 = (n > m4) ? (2 * n - m4) : n;
    iu2 = sq_ratio(2 * a, ir4);
    ou2 = sq_ratio(2 * a, 2 * n);
  endfunction

  function automatic logic [63:0] shape(input logic [63:0] iu2, input logic [63:0] ou2,
                                        input logic [63:0] ord);
    logic [63:0] s, s2, d;
    if (ou2 >= ONE_Q) return 0;
    if (ord == awm_pkg::ORD_SMOOTH) begin
      if (iu2 <= ONE_Q) return ONE_Q;
      s = ((ONE_Q - ou2) << awm_pkg::QF) / (iu2 - ou2);
      s2 = (s * s) >> awm_pkg::QF;
      return (s2 * (3 * ONE_Q - 2 * s)) >> awm_pkg::QF;
    end
    if (ord == awm_pkg::ORD_FILLET) begin
      if (iu2 <= ONE_Q) return ONE_Q - ((iu2 + ou2) >> 1);
      d = ONE_Q - ou2;
      return (d * d) / (2 * (iu2 - ou2));
    end
    d = ONE_Q - ou2;
    return (d * d) >> awm_pkg::QF;
  endfunction

  function automatic logic [16:0] mask_at(input logic [11:0] col, input logic [11:0] row);
    logic [63:0] w, h, ord, ix, ox, iy, oy, v;
    w = width_r;
    h = height_r;
    ord = (order_r > awm_pkg::ORD_HANN) ? awm_pkg::ORD_HANN : order_r;
    if (w == 0 || h == 0) return 0;
    if (w > MAX_DIM) w = MAX_DIM;
    if (h > MAX_DIM) h = MAX_DIM;
    axis_ratios(col, w, ord, ix, ox);
    axis_ratios(row, h, ord, iy, oy);
    if (round_r) v = shape(ix + iy, ox + oy, ord);
    else v = (shape(ix, ox, ord) * shape(iy, oy, ord)) >> awm_pkg::QF;
    v = v >> (awm_pkg::QF - 16);
    if (v > 65536) v = 65536;
    return v[16:0];
  endfunction

  assign pending = mask_q.size();

  always @(posedge clk) begin
    if (rst) begin
      width_r <= 256;
      height_r <= 256;
      order_r <= awm_pkg::ORD_SMOOTH;
      round_r <= 1'b1;
      mask_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          awm_pkg::REG_WIDTH: width_r <= cfg_data;
          awm_pkg::REG_HEIGHT: height_r <= cfg_data;
          awm_pkg::REG_ORDER: order_r <= cfg_data[1:0];
          awm_pkg::REG_ROUND: round_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) mask_q.push_back(mask_at(s_tdata[11:0], s_tdata[23:12]));
      if (m_tvalid && m_tready) begin
        if (mask_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %0d", $time, m_tdata[16:0]);
          fail_count <= fail_count + 1;
        end else begin
          if (m_tdata[16:0] !== mask_q[0]) begin
            $display("%0t: mask_value expected %0d actual %0d", $time, mask_q[0],
                     m_tdata[16:0]);
            fail_count <= fail_count + 1;
          end
          void'(mask_q.pop_front());
        end
      end
    end
  end
endmodule

@@ bench/antialiased_window_mask_pixel_unit_test.sv @@
`timescale 1ns / 1ps

module antialiased_window_mask_pixel_unit_test;

  localparam int LATENCY = 68;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk, rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [23:0] s_tdata, m_tdata;
  int          fail_count, pending;
  longint      cycles;
  bit          quiet_tail;

  antialiased_window_mask_pixel_unit u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  antialiased_window_mask_pixel_unit_checker u_check (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // output stall bursts
  initial begin
    int n;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(posedge clk);
        @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    int n;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup(input logic [12:0] w, input logic [12:0] h, input logic [1:0] ord,
                       input logic rnd);
    write_reg(awm_pkg::REG_WIDTH, w);
    write_reg(awm_pkg::REG_HEIGHT, h);
    write_reg(awm_pkg::REG_ORDER, {11'b0, ord});
    write_reg(awm_pkg::REG_ROUND, {12'b0, rnd});
  endtask

  initial begin
    logic [12:0] w, h;
    logic [11:0] c, r;
    rst = 1;
    cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
    s_tvalid = 0; s_tdata = 0;
    quiet_tail = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: corners, centre, out of range
    send_pixel(0, 0); send_pixel(127, 128); send_pixel(255, 255);
    send_pixel(4095, 4095); send_pixel(128, 0);
    drain();
    for (int o = 0; o < 4; o++) begin
      setup(o == 0 ? 13'd8191 : 13'd5, o == 1 ? 13'd0 : 13'd4096, o[1:0], o[0]);
      send_pixel(0, 4095); send_pixel(2, 2048); send_pixel(4095, 0); send_pixel(1, 1);
      drain();
    end
    setup(13'd1, 13'd1, awm_pkg::ORD_FILLET, 1'b0);
    send_pixel(0, 0); send_pixel(1, 0);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin w = 13'($urandom_range(1, 16)); h = 13'($urandom_range(1, 16)); end
        1: begin w = 13'($urandom_range(1, 300)); h = 13'($urandom_range(1, 300)); end
        2: begin w = 13'($urandom_range(1, 4096)); h = 13'($urandom_range(1, 4096)); end
        default: begin w = 13'($urandom_range(0, 8191)); h = 13'($urandom_range(0, 8191)); end
      endcase
      setup(w, h, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (ph == 15) quiet_tail = 1;
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          c = 12'($urandom); r = 12'($urandom);
        end else begin
          c = 12'($urandom_range(0, (w > 4096 || w == 0) ? 4095 : w - 1));
          r = 12'($urandom_range(0, (h > 4096 || h == 0) ? 4095 : h - 1));
        end
        send_pixel(c, r);
      end
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
